// ===== src/pnlc_pkg.sv =====
// shared types and constants for the pathname utf-8 / newline / length checker
// no dependencies
package pnlc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned LEN_W    = 12;
    localparam int unsigned COUNT_W  = 13;
    localparam int unsigned OWED_W   = 2;
    localparam int unsigned CLASS_W  = 3;

    localparam logic [LEN_W-1:0]   MAX_LENGTH_RST = LEN_W'(200);
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [BYTE_W-1:0]  NEWLINE_CHAR   = 8'h0A;

    // allowed range for the next continuation byte
    localparam logic [CLASS_W-1:0] CLS_80_BF = 3'd0;
    localparam logic [CLASS_W-1:0] CLS_A0_BF = 3'd1;
    localparam logic [CLASS_W-1:0] CLS_80_9F = 3'd2;
    localparam logic [CLASS_W-1:0] CLS_90_BF = 3'd3;
    localparam logic [CLASS_W-1:0] CLS_80_8F = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0] path_byte;
        logic              final_byte;
    } t_byte_req;

    typedef struct packed {
        logic bad_encoding;
        logic has_newline;
        logic too_long;
    } t_path_flags;

endpackage

// ===== src/pnlc_in_stage.sv =====
// input register for the byte stream
// depends on pnlc_pkg
module pnlc_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_data,
    input  logic                i_last,
    output logic                o_ready,
    input  logic                i_advance,
    output logic                o_valid,
    output pnlc_pkg::t_byte_req o_req
);
    import pnlc_pkg::*;

    logic      r_valid;
    t_byte_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req.path_byte  <= i_data;
            r_req.final_byte <= i_last;
        end
    end

endmodule

// ===== src/pnlc_path_tracker.sv =====
// per-path state: byte count, newline flag, utf-8 decoder, length limit register
// depends on pnlc_pkg
module pnlc_path_tracker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [11:0]           i_cfg_wdata,
    input  logic                  i_fire,
    input  pnlc_pkg::t_byte_req   i_req,
    output pnlc_pkg::t_path_flags o_flags
);
    import pnlc_pkg::*;

    logic [LEN_W-1:0]   r_max_length;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               r_newline, n_newline;
    logic [OWED_W-1:0]  r_owed, n_owed;
    logic [CLASS_W-1:0] r_class, n_class;
    logic               r_error, n_error;
    logic               in_range;
    logic [BYTE_W-1:0]  b;

    assign b = i_req.path_byte;

    always_comb begin
        unique case (r_class)
            CLS_A0_BF: in_range = (b >= 8'hA0) && (b <= 8'hBF);
            CLS_80_9F: in_range = (b >= 8'h80) && (b <= 8'h9F);
            CLS_90_BF: in_range = (b >= 8'h90) && (b <= 8'hBF);
            CLS_80_8F: in_range = (b >= 8'h80) && (b <= 8'h8F);
            default:   in_range = (b >= 8'h80) && (b <= 8'hBF);
        endcase
    end

    always_comb begin
        n_count   = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);
        n_newline = r_newline || (b == NEWLINE_CHAR);
        n_owed    = r_owed;
        n_class   = r_class;
        n_error   = r_error;
        if (r_owed != '0) begin
            n_class = CLS_80_BF;
            if (in_range) begin
                n_owed = r_owed - OWED_W'(1);
            end else begin
                n_error = 1'b1;
                n_owed  = '0;
            end
        end else begin
            priority if (b <= 8'h7F) begin
                n_owed = '0;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
                n_owed = 2'd1; n_class = CLS_80_BF;
            end else if (b == 8'hE0) begin
                n_owed = 2'd2; n_class = CLS_A0_BF;
            end else if (b == 8'hED) begin
                // excludes the surrogate block
                n_owed = 2'd2; n_class = CLS_80_9F;
            end else if (b >= 8'hE1 && b <= 8'hEF) begin
                n_owed = 2'd2; n_class = CLS_80_BF;
            end else if (b == 8'hF0) begin
                n_owed = 2'd3; n_class = CLS_90_BF;
            end else if (b >= 8'hF1 && b <= 8'hF3) begin
                n_owed = 2'd3; n_class = CLS_80_BF;
            end else if (b == 8'hF4) begin
                // caps at U+10FFFF
                n_owed = 2'd3; n_class = CLS_80_8F;
            end else begin
                n_error = 1'b1;
            end
        end
    end

    assign o_flags.too_long     = n_count > {1'b0, r_max_length};
    assign o_flags.has_newline  = n_newline;
    assign o_flags.bad_encoding = n_error || (n_owed != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAX_LENGTH_RST;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_newline <= 1'b0;
            r_owed    <= '0;
            r_class   <= CLS_80_BF;
            r_error   <= 1'b0;
        end else if (i_fire) begin
            if (i_req.final_byte) begin
                r_count   <= '0;
                r_newline <= 1'b0;
                r_owed    <= '0;
                r_class   <= CLS_80_BF;
                r_error   <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_newline <= n_newline;
                r_owed    <= n_owed;
                r_class   <= n_class;
                r_error   <= n_error;
            end
        end
    end

endmodule

// ===== src/pnlc_out_stage.sv =====
// result register toward the master side
// depends on pnlc_pkg
module pnlc_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  pnlc_pkg::t_path_flags i_flags,
    output logic                  o_free,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [7:0]            o_data
);
    import pnlc_pkg::*;

    logic        r_valid;
    t_path_flags r_flags;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = {5'b0, r_flags.bad_encoding, r_flags.has_newline, r_flags.too_long};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_flags <= i_flags;
        end
    end

endmodule

// ===== src/pathname_utf8_newline_length_checker_core.sv =====
// Pathname checker: streams pathname bytes in on the slave side, one byte per
// request, tlast on the final byte of each path. Per path it counts bytes
// (saturating), watches for 0x0A and runs a strict RFC 3629 utf-8 decoder.
// On the final byte one result leaves on the master side with three flags:
// too long (count above the max length register), newline seen, bad encoding
// (including a sequence cut short at the end). Non-final bytes give no result.
// Throughput: one byte per clock, except that a final byte waits while the
// result slot is full. A final byte passes the input register, then decode
// and the result register, before its result shows on m_axis. The decoder
// state is a feedback loop around the path tracker; it sets the byte rate.
// Receiver stall: the result register holds; further non-final bytes still
// flow, and a new final byte waits in the input register until the result
// slot frees. Reset (i_rst_n low, synchronous) empties both registers, clears
// the path state and sets max length to 200. i_cfg_we writes max length.
// depends on pnlc_pkg, pnlc_in_stage, pnlc_path_tracker, pnlc_out_stage
module pathname_utf8_newline_length_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] path_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] too_long, [1] has_newline, [2] bad_encoding
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata
);
    import pnlc_pkg::*;

    logic        in_valid;
    t_byte_req   in_req;
    logic        out_free;
    logic        fire;
    t_path_flags flags;

    // a final byte needs a free result slot, others always pass
    assign fire = in_valid && (!in_req.final_byte || out_free);

    pnlc_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .i_data    (s_axis_tdata),
        .i_last    (s_axis_tlast),
        .o_ready   (s_axis_tready),
        .i_advance (fire),
        .o_valid   (in_valid),
        .o_req     (in_req)
    );

    pnlc_path_tracker u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_req       (in_req),
        .o_flags     (flags)
    );

    pnlc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire && in_req.final_byte),
        .i_flags (flags),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata)
    );

endmodule

// ===== src/pnlc_checker.sv =====
// port-level checks for the pathname checker core, attached by bind
// depends on pathname_utf8_newline_length_checker_core
module pnlc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tready,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata
);

    // a stalled result keeps its flags
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // only three flag bits carry data
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:3] == 5'b0)
        else $error("result padding not zero");

    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_rst_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready right after reset");

endmodule

bind pathname_utf8_newline_length_checker_core pnlc_checker u_pnlc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/pathname_utf8_newline_length_checker_core_test.sv =====
// self-checking testbench for pathname_utf8_newline_length_checker_core: random and directed
// pathnames in, per-path length / newline / utf-8 flags checked against an in-bench tracker
// depends on pnlc_pkg and the checker core rtl
`timescale 1ns / 100ps

module pathname_utf8_newline_length_checker_core_test;
    import pnlc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned SETTLE_CYCLES = 4;

    typedef enum int unsigned {
        IDLE_NONE, IDLE_SPARSE, IDLE_HEAVY
    } t_idle_mode;

    typedef enum int unsigned {
        CK_ASCII, CK_TWO, CK_E0, CK_THREE, CK_ED, CK_F0, CK_FOUR, CK_F4
    } t_char_kind;

    typedef enum int unsigned {
        BK_C0_C1, BK_HIGH_LEAD, BK_LONE_CONT, BK_OVERLONG3, BK_SURROGATE,
        BK_OVERLONG4, BK_ABOVE_MAX, BK_NOT_CONT, BK_NOISE, BK_TRUNCATED
    } t_bad_kind;

    typedef struct {
        t_byte_req req;
        bit        drain;   // hold this request until all outstanding flags are back
    } t_pending;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] path_byte
    logic        s_axis_tlast = 1'b0;    // final_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // [0] too_long, [1] has_newline, [2] bad_encoding
    logic        i_cfg_we = 1'b0;
    logic [11:0] i_cfg_wdata = 12'd0;

    pathname_utf8_newline_length_checker_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // tracker copy of the path state
    logic [LEN_W-1:0]   trk_max_len = MAX_LENGTH_RST;
    logic [COUNT_W-1:0] trk_count = '0;
    logic               trk_newline = 1'b0;
    logic [OWED_W-1:0]  trk_owed = '0;
    logic [CLASS_W-1:0] trk_class = CLS_80_BF;
    logic               trk_error = 1'b0;

    t_pending    pending_q[$];
    t_path_flags flags_q[$];
    logic [7:0]  path_buf[$];

    t_idle_mode  src_mode = IDLE_SPARSE;
    t_idle_mode  snk_mode = IDLE_SPARSE;
    int unsigned src_gap = 0;
    int unsigned snk_wait = 0;
    int unsigned cycles = 0;
    int unsigned err_count = 0;
    int unsigned bytes_sent = 0;
    int unsigned paths_done = 0;
    int unsigned n_settings = 1;
    int unsigned n_long = 0;
    int unsigned n_newline = 0;
    int unsigned n_bad = 0;

    function automatic int unsigned draw_wait(input t_idle_mode mode);
        case (mode)
            IDLE_NONE:   return 0;
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
            default:     return $urandom_range(0, 12);
        endcase
    endfunction

    function automatic bit cont_in_range(input logic [7:0] b, input logic [CLASS_W-1:0] cls);
        case (cls)
            CLS_A0_BF: return b >= 8'hA0 && b <= 8'hBF;
            CLS_80_9F: return b >= 8'h80 && b <= 8'h9F;
            CLS_90_BF: return b >= 8'h90 && b <= 8'hBF;
            CLS_80_8F: return b >= 8'h80 && b <= 8'h8F;
            default:   return b >= 8'h80 && b <= 8'hBF;
        endcase
    endfunction

    // advance the tracker by one accepted byte, queue the flags on a final byte
    function automatic void track_byte(input logic [7:0] b, input logic last);
        t_path_flags f;
        if (trk_count != COUNT_MAX) trk_count = trk_count + COUNT_W'(1);
        if (b == NEWLINE_CHAR) trk_newline = 1'b1;
        if (trk_owed != '0) begin
            if (cont_in_range(b, trk_class)) begin
                trk_owed = trk_owed - OWED_W'(1);
            end else begin
                trk_error = 1'b1;
                trk_owed = '0;
            end
            trk_class = CLS_80_BF;
        end else if (b >= 8'h80) begin
            if (b >= 8'hC2 && b <= 8'hDF) begin
                trk_owed = 2'd1; trk_class = CLS_80_BF;
            end else if (b == 8'hE0) begin
                trk_owed = 2'd2; trk_class = CLS_A0_BF;
            end else if (b == 8'hED) begin
                trk_owed = 2'd2; trk_class = CLS_80_9F;
            end else if (b >= 8'hE1 && b <= 8'hEF) begin
                trk_owed = 2'd2; trk_class = CLS_80_BF;
            end else if (b == 8'hF0) begin
                trk_owed = 2'd3; trk_class = CLS_90_BF;
            end else if (b >= 8'hF1 && b <= 8'hF3) begin
                trk_owed = 2'd3; trk_class = CLS_80_BF;
            end else if (b == 8'hF4) begin
                trk_owed = 2'd3; trk_class = CLS_80_8F;
            end else begin
                trk_error = 1'b1;
            end
        end
        if (last) begin
            f.too_long     = trk_count > {1'b0, trk_max_len};
            f.has_newline  = trk_newline;
            f.bad_encoding = trk_error || (trk_owed != '0);
            flags_q.push_back(f);
            trk_count   = '0;
            trk_newline = 1'b0;
            trk_owed    = '0;
            trk_class   = CLS_80_BF;
            trk_error   = 1'b0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on result %0d: %s got %0h expected %0h", paths_done, what, got, want);
        err_count++;
    endtask

    // driver: pops pending requests, inserts the drawn gaps
    always @(posedge i_clk) begin : drv
        t_pending nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_gap <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                track_byte(s_axis_tdata, s_axis_tlast);
                bytes_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    src_gap <= src_gap - 1;
                end else if (pending_q.size() != 0 &&
                             !(pending_q[0].drain && flags_q.size() != 0)) begin
                    nxt = pending_q.pop_front();
                    s_axis_tdata  <= nxt.req.path_byte;
                    s_axis_tlast  <= nxt.req.final_byte;
                    s_axis_tvalid <= 1'b1;
                    src_gap <= draw_wait(src_mode);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: stalls the result side, compares each result with the oldest flags
    always @(posedge i_clk) begin : mon
        t_path_flags want;
        int unsigned w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait <= 0;
        end else begin
            w = snk_wait;
            if (m_axis_tvalid && m_axis_tready) begin
                if (flags_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata, 8'h00);
                end else begin
                    want = flags_q.pop_front();
                    if (m_axis_tdata[0] !== want.too_long)
                        report_mismatch("too_long", 8'(m_axis_tdata[0]), 8'(want.too_long));
                    if (m_axis_tdata[1] !== want.has_newline)
                        report_mismatch("has_newline", 8'(m_axis_tdata[1]),
                                        8'(want.has_newline));
                    if (m_axis_tdata[2] !== want.bad_encoding)
                        report_mismatch("bad_encoding", 8'(m_axis_tdata[2]),
                                        8'(want.bad_encoding));
                    if (m_axis_tdata[7:3] !== 5'd0)
                        report_mismatch("padding", 8'(m_axis_tdata[7:3]), 8'h00);
                    n_long    += want.too_long;
                    n_newline += want.has_newline;
                    n_bad     += want.bad_encoding;
                end
                paths_done++;
                w = draw_wait(snk_mode);
            end
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                snk_wait <= w - 1;
            end else begin
                m_axis_tready <= 1'b1;
                snk_wait <= 0;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d flags outstanding", cycles, flags_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic add_byte(input int unsigned lo, input int unsigned hi);
        path_buf.push_back(8'($urandom_range(lo, hi)));
    endtask

    task automatic add_valid_char();
        t_char_kind  k;
        logic [7:0]  lead;
        k = t_char_kind'($urandom_range(0, int'(CK_F4)));
        case (k)
            CK_ASCII: add_byte(8'h00, 8'h7F);
            CK_TWO: begin
                add_byte(8'hC2, 8'hDF); add_byte(8'h80, 8'hBF);
            end
            CK_E0: begin
                path_buf.push_back(8'hE0); add_byte(8'hA0, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            CK_THREE: begin
                lead = 8'($urandom_range(8'hE1, 8'hEE));
                if (lead == 8'hED) lead = 8'hEF;
                path_buf.push_back(lead);
                add_byte(8'h80, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            CK_ED: begin
                path_buf.push_back(8'hED); add_byte(8'h80, 8'h9F); add_byte(8'h80, 8'hBF);
            end
            CK_F0: begin
                path_buf.push_back(8'hF0); add_byte(8'h90, 8'hBF);
                add_byte(8'h80, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            CK_FOUR: begin
                add_byte(8'hF1, 8'hF3);
                repeat (3) add_byte(8'h80, 8'hBF);
            end
            default: begin
                path_buf.push_back(8'hF4); add_byte(8'h80, 8'h8F);
                add_byte(8'h80, 8'hBF); add_byte(8'h80, 8'hBF);
            end
        endcase
    endtask

    task automatic add_bad_frag();
        t_bad_kind k;
        k = t_bad_kind'($urandom_range(0, int'(BK_TRUNCATED)));
        case (k)
            BK_C0_C1: begin
                add_byte(8'hC0, 8'hC1); add_byte(8'h80, 8'hBF);
            end
            BK_HIGH_LEAD: add_byte(8'hF5, 8'hFF);
            BK_LONE_CONT: add_byte(8'h80, 8'hBF);
            BK_OVERLONG3: begin
                path_buf.push_back(8'hE0); add_byte(8'h80, 8'h9F); add_byte(8'h80, 8'hBF);
            end
            BK_SURROGATE: begin
                path_buf.push_back(8'hED); add_byte(8'hA0, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            BK_OVERLONG4: begin
                path_buf.push_back(8'hF0); add_byte(8'h80, 8'h8F);
                add_byte(8'h80, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            BK_ABOVE_MAX: begin
                path_buf.push_back(8'hF4); add_byte(8'h90, 8'hBF);
                add_byte(8'h80, 8'hBF); add_byte(8'h80, 8'hBF);
            end
            BK_NOT_CONT: begin
                add_byte(8'hC2, 8'hDF);
                if ($urandom_range(0, 1) == 0) add_byte(8'h00, 8'h7F);
                else add_byte(8'hC0, 8'hFF);
            end
            BK_NOISE: repeat ($urandom_range(1, 4)) add_byte(8'h00, 8'hFF);
            default: begin
                // multi-byte lead with too few continuation bytes
                if ($urandom_range(0, 1) == 0) add_byte(8'hE1, 8'hEC);
                else add_byte(8'hF1, 8'hF3);
                repeat ($urandom_range(0, 1)) add_byte(8'h80, 8'hBF);
            end
        endcase
    endtask

    task automatic build_path(input int unsigned target, input bit broken);
        int unsigned cut;
        bit          bad_done;
        path_buf.delete();
        cut = $urandom_range(0, target);
        bad_done = !broken;
        while (path_buf.size() < target) begin
            if (!bad_done && path_buf.size() >= cut) begin
                add_bad_frag();
                bad_done = 1'b1;
            end else if ($urandom_range(0, 31) == 0) begin
                path_buf.push_back(NEWLINE_CHAR);
            end else begin
                add_valid_char();
            end
        end
        if (!bad_done) add_bad_frag();
    endtask

    task automatic build_plain(input int unsigned n);
        path_buf.delete();
        repeat (n) add_byte(8'h20, 8'h7E);
    endtask

    task automatic queue_path(input bit drain_first);
        t_pending p;
        for (int unsigned i = 0; i < path_buf.size(); i++) begin
            p.req.path_byte  = path_buf[i];
            p.req.final_byte = (i == path_buf.size() - 1);
            p.drain = drain_first && (i == 0);
            pending_q.push_back(p);
        end
    endtask

    task automatic run_random(input int unsigned total, input int unsigned len_hi);
        int unsigned sent;
        bit          drained;
        sent = 0;
        drained = 1'b0;
        while (sent < total) begin
            build_path($urandom_range(1, len_hi), $urandom_range(0, 3) == 0);
            queue_path(!drained && sent >= total / 2);
            if (sent >= total / 2) drained = 1'b1;
            sent += path_buf.size();
        end
    endtask

    // no register write while anything is in flight
    task automatic wait_quiet();
        do @(negedge i_clk);
        while (pending_q.size() != 0 || s_axis_tvalid || flags_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_len(input logic [LEN_W-1:0] v);
        wait_quiet();
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        trk_max_len = v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    task automatic boundary_paths();
        build_plain(trk_max_len);
        if (path_buf.size() != 0) queue_path(1'b0);
        build_plain(trk_max_len + 1);
        queue_path(1'b0);
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset limit of 200
        path_buf = {8'h00};                        queue_path(1'b0);
        path_buf = {8'h0A, 8'h7F};                 queue_path(1'b0);
        path_buf = {8'hC2, 8'h80, 8'hDF, 8'hBF};   queue_path(1'b0);
        path_buf = {8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF};
        queue_path(1'b0);
        path_buf = {8'hF0, 8'h90, 8'h80, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
        queue_path(1'b0);
        // sequence cut short at the end
        path_buf = {8'hE1, 8'h80};                 queue_path(1'b0);
        // bad continuation, error stays after a good byte
        path_buf = {8'hC2, 8'h41, 8'h20};          queue_path(1'b0);
        path_buf = {8'hFF};                        queue_path(1'b0);

        set_max_len(12'd0);
        src_mode = IDLE_HEAVY;
        snk_mode = IDLE_HEAVY;
        run_random(200, 12);

        // longest limit, nothing reaches it
        set_max_len(12'd4095);
        src_mode = IDLE_NONE;
        snk_mode = IDLE_NONE;
        run_random(60, 20);

        set_max_len(12'($urandom_range(1, 40)));
        src_mode = IDLE_SPARSE;
        snk_mode = IDLE_HEAVY;
        boundary_paths();
        run_random(200, 48);

        set_max_len(12'($urandom_range(1, 40)));
        src_mode = IDLE_HEAVY;
        snk_mode = IDLE_SPARSE;
        boundary_paths();
        run_random(200, 48);

        set_max_len(MAX_LENGTH_RST);
        src_mode = IDLE_SPARSE;
        snk_mode = IDLE_NONE;
        boundary_paths();
        run_random(100, 48);

        wait_quiet();
        repeat (8) @(posedge i_clk);
        $display("checked %0d paths (%0d bytes) under %0d length limits",
                 paths_done, bytes_sent, n_settings);
        $display("flags seen: %0d too long, %0d with newline, %0d bad encoding",
                 n_long, n_newline, n_bad);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", err_count);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
